### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks with reset masking, used by the top-level queue file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check, masked while reset is asserted.
`define SPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Same check on the house clock and reset names.
`define SPQ_ASSERT_TOP(name, prop) \
  `SPQ_ASSERT(name, clk_i, rst_ni, prop)

`endif

### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, codes and control types of the sorted priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int CODE_BITS = 32;
  localparam int PRIO_BITS = 8;

  // Item field widths.
  localparam int CMD_BITS      = 2;
  localparam int TAG_BITS      = 32;
  localparam int IN_PRIO_BITS  = 8;
  localparam int STATUS_BITS   = 2;
  localparam int OCC_BITS      = 5;

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  // Command decode: high bit selects dequeue, otherwise low code picks insert.
  localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd1;
  localparam int                  CMD_DEQ_BIT = 1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_STORED = 2'd0,
    ST_VALID  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_POP
  } op_e;

  typedef struct packed {
    logic    load;
    op_e     op;
    status_e res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

### src/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: command, task tag and priority with valid/ready.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::CMD_BITS-1:0]        command;
  logic [spq_pkg::TAG_BITS-1:0]        task_code;
  logic [spq_pkg::IN_PRIO_BITS-1:0]    task_priority;

  modport source (output valid, command, task_code, task_priority, input ready);
  modport sink   (input valid, command, task_code, task_priority, output ready);
endinterface

### src/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel: status, dequeued tag and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [spq_pkg::STATUS_BITS-1:0]    status;
  logic [spq_pkg::TAG_BITS-1:0]       out_code;
  logic [spq_pkg::OCC_BITS-1:0]       occupancy;

  modport source (output valid, status, out_code, occupancy, input ready);
  modport sink   (input valid, status, out_code, occupancy, output ready);
endinterface

### src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: decodes commands and holds the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [spq_pkg::CMD_BITS-1:0]  req_command_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  input  spq_pkg::dp_stat_t             stat_i,
  output spq_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   accept;

  // A waiting result leaves as the next item comes in.
  assign req_ready_o = (state_q == S_IDLE) || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = (state_q == S_RESULT);

  always_comb begin
    cmd_o.load       = accept;
    cmd_o.op         = spq_pkg::OP_HOLD;
    cmd_o.res_status = spq_pkg::ST_STORED;
    if (req_command_i[spq_pkg::CMD_DEQ_BIT]) begin
      if (stat_i.empty) begin
        cmd_o.res_status = spq_pkg::ST_EMPTY;
      end else begin
        cmd_o.op         = spq_pkg::OP_POP;
        cmd_o.res_status = spq_pkg::ST_VALID;
      end
    end else if (stat_i.full) begin
      cmd_o.res_status = spq_pkg::ST_FULL;
    end else if (req_command_i == spq_pkg::CMD_INSERT) begin
      cmd_o.op = spq_pkg::OP_INSERT;
    end else begin
      cmd_o.op = spq_pkg::OP_APPEND;
    end
    if (!accept) begin
      cmd_o.op = spq_pkg::OP_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_ready_i && !accept) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### src/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Sorted store of compare-and-shift cells plus the result register.
// ----------------------------------------------------------------------------
module spq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::dp_cmd_t                  cmd_i,
  input  logic [spq_pkg::TAG_BITS-1:0]      code_i,
  input  logic [spq_pkg::IN_PRIO_BITS-1:0]  prio_i,
  output spq_pkg::dp_stat_t                 stat_o,
  output logic [spq_pkg::STATUS_BITS-1:0]   status_o,
  output logic [spq_pkg::TAG_BITS-1:0]      out_code_o,
  output logic [spq_pkg::OCC_BITS-1:0]      occupancy_o
);

  logic [spq_pkg::CODE_BITS-1:0] codes_q [spq_pkg::DEPTH];
  logic [spq_pkg::CODE_BITS-1:0] codes_d [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_BITS-1:0] prios_q [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_BITS-1:0] prios_d [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_BITS-1:0]  count_q, count_d;

  logic [spq_pkg::DEPTH-1:0]     take;
  logic [spq_pkg::DEPTH-1:0]     prev_take;
  logic [spq_pkg::CODE_BITS-1:0] new_code;
  logic [spq_pkg::PRIO_BITS-1:0] new_prio;
  logic                          is_put;

  assign stat_o.full  = (count_q == spq_pkg::CNT_BITS'(spq_pkg::DEPTH));
  assign stat_o.empty = (count_q == '0);

  assign new_code = spq_pkg::CODE_BITS'(code_i);
  assign new_prio = (cmd_i.op == spq_pkg::OP_INSERT) ? spq_pkg::PRIO_BITS'(prio_i) : '0;
  assign is_put   = (cmd_i.op == spq_pkg::OP_APPEND) || (cmd_i.op == spq_pkg::OP_INSERT);

  // Cell takes part in the shift if it is free or, on insert, holds a priority not
  // above the new one; the vector is monotonic since the store stays sorted.
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      take[i] = (spq_pkg::CNT_BITS'(i) >= count_q) ||
                ((cmd_i.op == spq_pkg::OP_INSERT) && (prios_q[i] <= new_prio));
    end
    prev_take = {take[spq_pkg::DEPTH-2:0], 1'b0};
  end

  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      codes_d[i] = codes_q[i];
      prios_d[i] = prios_q[i];
    end
    count_d = count_q;
    case (cmd_i.op)
      spq_pkg::OP_POP: begin
        for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
          codes_d[i] = codes_q[i+1];
          prios_d[i] = prios_q[i+1];
        end
        count_d = count_q - 1'b1;
      end
      spq_pkg::OP_APPEND, spq_pkg::OP_INSERT: begin
        if (take[0]) begin
          codes_d[0] = new_code;
          prios_d[0] = new_prio;
        end
        for (int i = 1; i < spq_pkg::DEPTH; i++) begin
          if (take[i]) begin
            codes_d[i] = prev_take[i] ? codes_q[i-1] : new_code;
            prios_d[i] = prev_take[i] ? prios_q[i-1] : new_prio;
          end
        end
        count_d = count_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (is_put || (cmd_i.op == spq_pkg::OP_POP)) begin
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
        codes_q[i] <= codes_d[i];
        prios_q[i] <= prios_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register, loaded with each accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o    <= cmd_i.res_status;
      out_code_o  <= (cmd_i.op == spq_pkg::OP_POP) ?
                     spq_pkg::TAG_BITS'(codes_q[0]) : '0;
      occupancy_o <= spq_pkg::OCC_BITS'(count_d);
    end
  end

endmodule

### src/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Bounded task queue held in descending priority order.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req_i carries command (append at tail with priority 0, insert by
//    priority, dequeue head; command three acts as dequeue), a 32-bit task
//    tag and an 8-bit priority. Equal priorities: newest inserted goes first.
//  - rsp_o returns one item per request: status (stored, dequeued, empty,
//    full-rejected), the dequeued tag (zero otherwise) and the occupancy
//    after the operation.
//  - The result is registered at the accepting edge and shows on rsp_o in the
//    next cycle.
//  - Throughput: one item per cycle unless a waiting result stalls. Each cell
//    of the store compares its priority with the new one in parallel and
//    shifts by one place.
//  - Stall: while a result waits unaccepted, req_i.ready follows
//    rsp_o.ready; the waiting result leaves in the same edge that takes the
//    next request.
//  - Reset (rst_ni, asynchronous, active low) empties the queue and drops any
//    pending result. The store contents are not cleared; only occupied slots
//    are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_task_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;

  // Helpers for the checks below.
  logic [spq_pkg::OCC_BITS-1:0] occ_max;
  logic                         rsp_deq;
  logic                         rsp_full;

  spq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_command_i (req_i.command),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .stat_i        (dp_stat),
    .cmd_o         (dp_cmd)
  );

  spq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .code_i      (req_i.task_code),
    .prio_i      (req_i.task_priority),
    .stat_o      (dp_stat),
    .status_o    (rsp_o.status),
    .out_code_o  (rsp_o.out_code),
    .occupancy_o (rsp_o.occupancy)
  );

  assign occ_max  = spq_pkg::OCC_BITS'(spq_pkg::DEPTH);
  assign rsp_deq  = (rsp_o.status == spq_pkg::ST_VALID);
  assign rsp_full = (rsp_o.status == spq_pkg::ST_FULL);

  // Occupancy never runs past the store size.
  `SPQ_ASSERT_TOP(a_occ_bound, rsp_o.valid |-> (rsp_o.occupancy <= occ_max))

  // Tag is zero unless a task was actually dequeued.
  `SPQ_ASSERT_TOP(a_code_zero, (rsp_o.valid && !rsp_deq) |-> (rsp_o.out_code == '0))

  // A rejected store only happens with the queue full.
  `SPQ_ASSERT_TOP(a_full_occ, (rsp_o.valid && rsp_full) |-> (rsp_o.occupancy == occ_max))

  // A request is never taken over a stalled result.
  `SPQ_ASSERT_TOP(a_no_overwrite, (req_i.valid && req_i.ready) |-> !(rsp_o.valid && !rsp_o.ready))

endmodule
